// ----- sv/dpc_pkg.sv -----
// Shared types, constants and helpers for the disparity to point cloud unit.
package dpc_pkg;

  localparam int unsigned POS_W  = 13;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned DIV_W  = 53;
  localparam int unsigned DEN_W  = 20;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned OUT_DW = 104;

  localparam logic [12:0] RST_IMAGE_WIDTH = 13'd1024;
  localparam logic [2:0]  RST_SAMPLE_STEP = 3'd2;
  localparam logic [19:0] RST_FOCAL_X     = 20'd184027;
  localparam logic [19:0] RST_FOCAL_Y     = 20'd184027;
  localparam logic [19:0] RST_CENTER_X    = 20'd155441;
  localparam logic [19:0] RST_CENTER_Y    = 20'd47415;
  localparam logic [15:0] RST_BASELINE    = 16'd2347;

  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_SAMPLE_STEP = 3'd1;
  localparam logic [2:0] REG_FOCAL_X     = 3'd2;
  localparam logic [2:0] REG_FOCAL_Y     = 3'd3;
  localparam logic [2:0] REG_CENTER_X    = 3'd4;
  localparam logic [2:0] REG_CENTER_Y    = 3'd5;
  localparam logic [2:0] REG_BASELINE    = 3'd6;

  typedef struct packed {
    logic [12:0] image_width;
    logic [2:0]  sample_step;
    logic [19:0] focal_x;
    logic [19:0] focal_y;
    logic [19:0] center_x;
    logic [19:0] center_y;
    logic [15:0] baseline;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       gray;
    logic [7:0]       disp;
    logic [POS_W-1:0] col;
    logic [ROW_W-1:0] row;
  } entry_t;

  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [30:0] depth;
    logic [7:0]  point_gray;
    logic        depth_valid;
  } point_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DEPTH, B_XMUL, B_XDIV, B_YMUL, B_YDIV, B_OUT
  } back_state_e;

  // Effective step: zero acts as one, above four acts as four.
  function automatic logic [2:0] eff_step(input logic [2:0] s);
    logic [2:0] r;
    r = s;
    if (s == 3'd0) r = 3'd1;
    if (s > 3'd4) r = 3'd4;
    return r;
  endfunction

  // True when v is a multiple of step (step 1..4).
  function automatic logic on_grid(input logic [12:0] v, input logic [2:0] step);
    logic [25:0] prod;
    logic [12:0] q3;
    logic [14:0] back3;
    logic        r;
    prod  = 26'(v) * 26'd2731;
    q3    = prod[25:13];
    back3 = 15'(q3) * 15'd3;
    r     = 1'b1;
    case (step)
      3'd2:    r = (v[0] == 1'b0);
      3'd3:    r = (back3 == 15'(v));
      3'd4:    r = (v[1:0] == 2'b00);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [19:0] eff_focal(input logic [19:0] f);
    return (f == 20'd0) ? 20'd1 : f;
  endfunction

endpackage

// ----- sv/dpc_front.sv -----
// Front end: pixel position counters and sampling-grid selection.
module dpc_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpc_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  input  logic [7:0]          gray_i,
  input  logic [7:0]          disp_i,
  input  logic                first_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output dpc_pkg::entry_t     push_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;

  logic [CW-1:0]               col_q, col_d, col_cur;
  logic [dpc_pkg::ROW_W-1:0]   row_q, row_d, row_cur, row_start;
  logic [WW-1:0]               width_eff;
  logic [31:0]                 width_ext;
  logic [WW-1:0]               col_inc;
  logic [2:0]                  step;
  logic                        accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;
  assign step       = dpc_pkg::eff_step(cfg_i.sample_step);
  assign width_ext  = 32'(cfg_i.image_width);

  always_comb begin
    if (width_ext == 32'd0) begin
      width_eff = WW'(1);
    end else if (width_ext > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_ext);
    end
  end

  always_comb begin
    col_cur   = first_i ? '0 : col_q;
    row_start = first_i ? '0 : row_q;
    row_cur   = row_start;
    if (WW'(col_cur) >= width_eff) begin
      col_cur = '0;
      row_cur = row_start + 1'b1;
    end
    col_inc = WW'(col_cur) + 1'b1;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= width_eff) begin
        col_d = '0;
        row_d = row_cur + 1'b1;
      end else begin
        col_d = col_inc[CW-1:0];
        row_d = row_cur;
      end
    end
  end

  assign push_o = accept &&
                  dpc_pkg::on_grid(13'(col_cur), step) &&
                  dpc_pkg::on_grid(13'(row_cur), step);

  always_comb begin
    push_data_o.gray = gray_i;
    push_data_o.disp = disp_i;
    push_data_o.col  = dpc_pkg::POS_W'(col_cur);
    push_data_o.row  = row_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- sv/dpc_queue.sv -----
// Two-entry request queue between front end and back end.
module dpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dpc_pkg::entry_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output dpc_pkg::entry_t data_o
);

  dpc_pkg::entry_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- sv/dpc_back.sv -----
// Back end: depth and reprojection through one shared serial divider.
module dpc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpc_pkg::cfg_t   cfg_i,
  input  logic            q_valid_i,
  input  dpc_pkg::entry_t q_data_i,
  output logic            pop_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output dpc_pkg::point_t out_o
);

  localparam int unsigned DW = dpc_pkg::DIV_W;

  dpc_pkg::back_state_e state_q, state_d;
  dpc_pkg::entry_t      ent_q, ent_d;
  dpc_pkg::point_t      res_q, res_d, out_q, out_d;
  logic                 out_v_q, out_v_d;
  logic [DW-1:0]        num_q, num_d, num_n;
  logic [dpc_pkg::DEN_W:0]   rem_q, rem_d, rem_sh, rem_n;
  logic [dpc_pkg::DEN_W-1:0] den_q, den_d;
  logic [dpc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                 neg_q, neg_d, ge, last;
  logic [19:0]          fxe, fye, cen, foc;
  logic [20:0]          pos_p, mag;
  logic                 neg_c;

  assign fxe    = dpc_pkg::eff_focal(cfg_i.focal_x);
  assign fye    = dpc_pkg::eff_focal(cfg_i.focal_y);
  assign rem_sh = {rem_q[dpc_pkg::DEN_W-1:0], num_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_n  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign num_n  = {num_q[DW-2:0], ge};
  assign last   = (cnt_q == dpc_pkg::CNT_W'(DW - 1));

  function automatic logic [31:0] sat32(input logic [DW-1:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      r = (q >= DW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(0) - q[31:0];
    end
    return r;
  endfunction

  always_comb begin
    if (state_q == dpc_pkg::B_YMUL) begin
      pos_p = {1'b0, ent_q.row, 8'd0};
      cen   = cfg_i.center_y;
      foc   = fye;
    end else begin
      pos_p = {ent_q.col, 8'd0};
      cen   = cfg_i.center_x;
      foc   = fxe;
    end
    neg_c = pos_p < 21'(cen);
    mag   = neg_c ? 21'(cen) - pos_p : pos_p - 21'(cen);
  end

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    res_d   = res_q;
    out_d   = out_q;
    out_v_d = out_v_q && !out_ready_i;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    pop_o   = 1'b0;
    unique case (state_q)
      dpc_pkg::B_IDLE: begin
        if (q_valid_i) begin
          pop_o            = 1'b1;
          ent_d            = q_data_i;
          res_d.point_gray = q_data_i.gray;
          if (q_data_i.disp == 8'd0) begin
            res_d.x_pos       = '0;
            res_d.y_pos       = '0;
            res_d.depth       = '0;
            res_d.depth_valid = 1'b0;
            state_d           = dpc_pkg::B_OUT;
          end else begin
            res_d.depth_valid = 1'b1;
            num_d   = DW'(36'(fxe) * 36'(cfg_i.baseline)) + DW'({q_data_i.disp, 7'd0});
            den_d   = dpc_pkg::DEN_W'({q_data_i.disp, 8'd0});
            rem_d   = '0;
            cnt_d   = '0;
            state_d = dpc_pkg::B_DEPTH;
          end
        end
      end
      dpc_pkg::B_DEPTH, dpc_pkg::B_XDIV, dpc_pkg::B_YDIV: begin
        num_d = num_n;
        rem_d = rem_n;
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          case (state_q)
            dpc_pkg::B_DEPTH: begin
              res_d.depth = (num_n > DW'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : num_n[30:0];
              state_d     = dpc_pkg::B_XMUL;
            end
            dpc_pkg::B_XDIV: begin
              res_d.x_pos = sat32(num_n, neg_q);
              state_d     = dpc_pkg::B_YMUL;
            end
            default: begin
              res_d.y_pos = sat32(num_n, neg_q);
              state_d     = dpc_pkg::B_OUT;
            end
          endcase
        end
      end
      dpc_pkg::B_XMUL, dpc_pkg::B_YMUL: begin
        num_d   = DW'(52'(mag) * 52'(res_q.depth)) + DW'(foc[19:1]);
        den_d   = foc;
        neg_d   = neg_c;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = (state_q == dpc_pkg::B_XMUL) ? dpc_pkg::B_XDIV : dpc_pkg::B_YDIV;
      end
      dpc_pkg::B_OUT: begin
        if (!out_v_q || out_ready_i) begin
          out_d   = res_q;
          out_v_d = 1'b1;
          state_d = dpc_pkg::B_IDLE;
        end
      end
      default: state_d = dpc_pkg::B_IDLE;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    res_q <= res_d;
    out_q <= out_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpc_pkg::B_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

endmodule

// ----- sv/disparity_to_point_cloud_unit.sv -----
// Top level: configuration registers, front end, request queue and back end.
// Turns a raster stream of gray/disparity pixels into 3-D points. Column and row
// counters restart on the frame-start flag in tuser and wrap at image_width; only
// pixels whose column and row are multiples of sample_step give a point. Depth is
// focal_x*baseline/disparity, x and y are the centered position times depth over
// the focal length, all rounded to nearest and saturated; zero disparity gives a
// zero point with depth_valid low. Off-grid pixels are taken at one per clock while
// the queue has room. A sampled pixel occupies the back end through issue, three
// 53-step divisions on one shared serial divider, two multiply steps and output,
// while a zero-disparity pixel goes from issue straight to output. The back end
// takes a new pixel only after passing the last one to the output register; a
// two-entry queue and an output register let input and output stall independently.
module disparity_to_point_cloud_unit #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,  // gray, disparity_value
  input  logic          s_axis_tuser,  // first_of_frame
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,  // x_pos, y_pos, depth, point_gray, zero pad
  output logic          m_axis_tuser,  // depth_valid
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  dpc_pkg::cfg_t   cfg_q;
  dpc_pkg::entry_t push_data, q_data;
  dpc_pkg::point_t pt;
  logic            push, q_full, q_valid, pop;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= dpc_pkg::RST_IMAGE_WIDTH;
      cfg_q.sample_step <= dpc_pkg::RST_SAMPLE_STEP;
      cfg_q.focal_x     <= dpc_pkg::RST_FOCAL_X;
      cfg_q.focal_y     <= dpc_pkg::RST_FOCAL_Y;
      cfg_q.center_x    <= dpc_pkg::RST_CENTER_X;
      cfg_q.center_y    <= dpc_pkg::RST_CENTER_Y;
      cfg_q.baseline    <= dpc_pkg::RST_BASELINE;
    end else if (wr_en) begin
      unique case (reg_idx)
        dpc_pkg::REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[12:0];
        dpc_pkg::REG_SAMPLE_STEP: cfg_q.sample_step <= pwdata[2:0];
        dpc_pkg::REG_FOCAL_X:     cfg_q.focal_x     <= pwdata[19:0];
        dpc_pkg::REG_FOCAL_Y:     cfg_q.focal_y     <= pwdata[19:0];
        dpc_pkg::REG_CENTER_X:    cfg_q.center_x    <= pwdata[19:0];
        dpc_pkg::REG_CENTER_Y:    cfg_q.center_y    <= pwdata[19:0];
        dpc_pkg::REG_BASELINE:    cfg_q.baseline    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dpc_pkg::REG_IMAGE_WIDTH: prdata = 32'(cfg_q.image_width);
      dpc_pkg::REG_SAMPLE_STEP: prdata = 32'(cfg_q.sample_step);
      dpc_pkg::REG_FOCAL_X:     prdata = 32'(cfg_q.focal_x);
      dpc_pkg::REG_FOCAL_Y:     prdata = 32'(cfg_q.focal_y);
      dpc_pkg::REG_CENTER_X:    prdata = 32'(cfg_q.center_x);
      dpc_pkg::REG_CENTER_Y:    prdata = 32'(cfg_q.center_y);
      dpc_pkg::REG_BASELINE:    prdata = 32'(cfg_q.baseline);
      default:                  prdata = 32'd0;
    endcase
  end

  dpc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .gray_i      (s_axis_tdata[7:0]),
    .disp_i      (s_axis_tdata[15:8]),
    .first_i     (s_axis_tuser),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  dpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (pt)
  );

  assign m_axis_tdata = {1'b0, pt.point_gray, pt.depth, pt.y_pos, pt.x_pos};
  assign m_axis_tuser = pt.depth_valid;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("push into full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (pt.x_pos == 32'd0 && pt.y_pos == 32'd0 && pt.depth == 31'd0))
    else $error("invalid point with nonzero coordinates");

endmodule
